// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: entry layout,
// cell commands, action and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  // number of cells in the chain
  localparam int Capacity = 16;
  // most entries a list action reports
  localparam int MaxList  = 16;
  localparam int ListLim  = (Capacity < MaxList) ? Capacity : MaxList;
  // entry count, wide enough to hold Capacity itself
  localparam int CntW     = $clog2(Capacity + 1);

  localparam int DataW = 8;
  localparam int PrioW = 8;

  // input actions
  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_LIST    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_LISTED   = 3'd4
  } status_t;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } entry_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   key;   // entry being inserted
  } cell_ctrl_t;

endpackage

// ----- sv/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds one entry and on each command keeps
// it, takes the new entry, takes the entry of a neighbor, or (tail on rotate) the head entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occ,        // this slot holds a live entry
  input  logic               left_occ,   // left neighbor holds a live entry
  input  logic               is_tail,    // this slot is the last live one
  input  spq_pkg::entry_t    left_ent,
  input  spq_pkg::entry_t    right_ent,
  input  spq_pkg::entry_t    head_ent,
  output spq_pkg::entry_t    ent
);
  import spq_pkg::*;

  entry_t ent_next;
  logic   self_gt;
  logic   left_gt;

  // insertion: entries of equal priority stay ahead of the new one
  assign self_gt = !occ || (ent.prio > ctrl.key.prio);
  assign left_gt = left_occ && (left_ent.prio > ctrl.key.prio);

  always_comb begin
    ent_next = ent;
    case (ctrl.op)
      CELL_INSERT: begin
        if (self_gt) begin
          ent_next = left_gt ? left_ent : ctrl.key;
        end
      end
      CELL_SHIFT:  ent_next = right_ent;
      CELL_ROTATE: ent_next = is_tail ? head_ent : right_ent;
      default:     ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ----- sv/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue of byte entries kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ group: s_tuser carries the action (enqueue,
//   dequeue, list), s_tdata the data byte and priority. Results leave on the
//   m_ group: status, data and priority in m_tdata, m_tlast on the final
//   result of a request. Lower priority numbers leave first; equal
//   priorities leave in arrival order.
//   For enqueue and dequeue the whole chain shifts at once and the single
//   result is in the output register in the cycle after the request, so one
//   such item can be taken every cycle while m_tready holds.
//   A list action rotates the chain by one cell per cycle while the receiver
//   keeps up, reporting the head each time; the request first moves the
//   state to list, then the first entry is registered. s_tready stays low
//   until every entry has rotated; an empty queue gives a single ST_EMPTY
//   result instead. The chain is back in order afterwards.
//   Reset empties the queue (entry count zero). When the receiver stalls,
//   the output register holds its item and s_tready drops; a list pauses.
// ----------------------------------------------------------------------------
module stable_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] item_data, [15:8] item_priority
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] status, [10:3] out_data,
                                 // [18:11] out_priority, [23:19] zero
  output logic        m_tlast
);
  import spq_pkg::*;

  typedef enum logic {S_IDLE, S_LIST} state_t;

  state_t       state, state_next;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] idx, idx_next;
  logic [CntW-1:0] list_n;

  logic         out_valid, out_valid_next;
  status_t      out_status, out_status_next;
  entry_t       out_ent, out_ent_next;
  logic         out_last, out_last_next;

  cell_ctrl_t   ctrl;
  entry_t       ents [Capacity];
  logic [Capacity-1:0] occ;
  logic         out_free;
  logic         in_acc;
  logic         emit_ok;
  action_t      action;
  entry_t       in_ent;

  assign action      = action_t'(s_tuser);
  assign in_ent.data = s_tdata[7:0];
  assign in_ent.prio = s_tdata[15:8];

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;
  assign list_n   = (count > CntW'(ListLim)) ? CntW'(ListLim) : count;
  assign emit_ok  = idx < list_n;

  // chain of cells, head at cell 0
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_o;
    assign occ[i] = count > CntW'(i);
    if (i == 0) begin : g_head
      assign left_e = ents[0];
      assign left_o = 1'b0;
    end else begin : g_body
      assign left_e = ents[i-1];
      assign left_o = occ[i-1];
    end
    if (i == Capacity - 1) begin : g_end
      assign right_e = ents[i];
    end else begin : g_mid
      assign right_e = ents[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .left_occ  (left_o),
      .is_tail   (count == CntW'(i + 1)),
      .left_ent  (left_e),
      .right_ent (right_e),
      .head_ent  (ents[0]),
      .ent       (ents[i])
    );
  end

  // control and result selection
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    ctrl.op         = CELL_HOLD;
    ctrl.key        = in_ent;
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_ent_next    = out_ent;
    out_last_next   = out_last;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          out_ent_next  = '0;
          out_last_next = 1'b1;
          case (action)
            ACT_ENQUEUE: begin
              out_valid_next = 1'b1;
              if (count == CntW'(Capacity)) begin
                out_status_next = ST_FULL;
              end else begin
                ctrl.op         = CELL_INSERT;
                count_next      = count + 1'b1;
                out_status_next = ST_ENQUEUED;
              end
            end
            ACT_DEQUEUE: begin
              out_valid_next = 1'b1;
              if (count == '0) begin
                out_status_next = ST_EMPTY;
              end else begin
                ctrl.op         = CELL_SHIFT;
                count_next      = count - 1'b1;
                out_status_next = ST_DEQUEUED;
                out_ent_next    = ents[0];
              end
            end
            ACT_LIST: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EMPTY;
              end else begin
                state_next = S_LIST;
                idx_next   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        // rotate once per step; report while within the list limit
        if (!emit_ok || out_free) begin
          ctrl.op  = CELL_ROTATE;
          idx_next = idx + 1'b1;
          if (emit_ok) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_LISTED;
            out_ent_next    = ents[0];
            out_last_next   = (idx == list_n - 1'b1);
          end
          if (idx == count - 1'b1) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
    out_status <= out_status_next;
    out_ent    <= out_ent_next;
    out_last   <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_ent.prio, out_ent.data, out_status};
  assign m_tlast  = out_last;

`ifndef ASSERT_OFF
  // entry count never passes the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Capacity))
    else $error("entry count above capacity");

  // a list never changes the number of stored entries
  a_list_count: assert property (@(posedge clk) disable iff (rst)
    state == S_LIST |=> count == $past(count))
    else $error("entry count changed during list");

  // only listed entries can be followed by more results of one item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != ST_LISTED |-> m_tlast)
    else $error("single result without last marker");

  // an accepted enqueue into a non-full queue grows it by one
  a_enq_grow: assert property (@(posedge clk) disable iff (rst)
    in_acc && action == ACT_ENQUEUE && count != CntW'(Capacity)
      |=> count == $past(count) + 1'b1)
    else $error("enqueue did not add an entry");
`endif

endmodule

// ----- tb/sv/spq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_checker
// Passive checker for the stable priority queue. It mirrors the queue
// contents from the accepted request items, builds the results each request
// must produce, and compares every result item leaving the block against them
// in order.
// ----------------------------------------------------------------------------
module spq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] item_data, [15:8] item_priority
  input  logic [1:0]  s_tuser,   // [1:0] action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [2:0] status, [10:3] out_data,
                                 // [18:11] out_priority, [23:19] zero
  input  logic        m_tlast,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);
  import spq_pkg::*;

  typedef struct {
    status_t          status;
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
    logic             last;
  } queue_result_t;

  // results owed by the block, oldest first
  queue_result_t due_results[$];

  // sorted copy of the queue, head at index 0
  entry_t mirror_slots[Capacity];
  int     mirror_count;

  // apply one request to the mirror and queue up the results it causes
  function automatic void apply_request(action_t act, logic [DataW-1:0] d,
                                        logic [PrioW-1:0] p);
    int pos;
    int cnt;
    case (act)
      ACT_ENQUEUE: begin
        if (mirror_count >= Capacity) begin
          due_results.push_back('{ST_FULL, '0, '0, 1'b1});
        end else begin
          // land behind every entry of equal or more urgent priority
          pos = 0;
          while (pos < mirror_count && mirror_slots[pos].prio <= p) pos++;
          for (int i = mirror_count; i > pos; i--) mirror_slots[i] = mirror_slots[i-1];
          mirror_slots[pos].data = d;
          mirror_slots[pos].prio = p;
          mirror_count++;
          due_results.push_back('{ST_ENQUEUED, '0, '0, 1'b1});
        end
      end
      ACT_DEQUEUE: begin
        if (mirror_count == 0) begin
          due_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
        end else begin
          due_results.push_back('{ST_DEQUEUED, mirror_slots[0].data,
                                  mirror_slots[0].prio, 1'b1});
          for (int i = 1; i < mirror_count; i++) mirror_slots[i-1] = mirror_slots[i];
          mirror_count--;
        end
      end
      ACT_LIST: begin
        if (mirror_count == 0) begin
          due_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
        end else begin
          cnt = (mirror_count > MaxList) ? MaxList : mirror_count;
          for (int i = 0; i < cnt; i++)
            due_results.push_back('{ST_LISTED, mirror_slots[i].data,
                                    mirror_slots[i].prio, logic'(i == cnt - 1)});
        end
      end
      default: ;  // unused code: no effect, no result
    endcase
  endfunction

  // compare one result item with the oldest owed result
  task automatic check_result();
    queue_result_t    want;
    logic [2:0]       got_status;
    logic [DataW-1:0] got_data;
    logic [PrioW-1:0] got_prio;
    got_status = m_tdata[2:0];
    got_data   = m_tdata[10:3];
    got_prio   = m_tdata[18:11];
    checked++;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result: status=%0d data=%02h prio=%02h last=%0b",
               $time, got_status, got_data, got_prio, m_tlast);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      if (got_status !== want.status || got_data !== want.data ||
          got_prio !== want.prio || m_tlast !== want.last || m_tdata[23:19] !== '0) begin
        $display("%0t: mismatch: expected status=%0d data=%02h prio=%02h last=%0b pad=00",
                 $time, want.status, want.data, want.prio, want.last);
        $display("%0t:           actual   status=%0d data=%02h prio=%02h last=%0b pad=%02h",
                 $time, got_status, got_data, got_prio, m_tlast, m_tdata[23:19]);
        mismatches++;
      end
    end
  endtask

  // a result is registered after its request, so check results first
  always @(posedge clk) begin
    if (rst) begin
      mirror_count = 0;
      due_results.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) apply_request(action_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
    end
    outstanding = due_results.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the stable priority queue. A directed opening hits
// the empty, full, tie and extreme-priority cases; random phases then fill and
// drain the queue with random gaps and stalls on both streams, while the
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int RandomItems = 500;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;

  // directed fill: extremes and ties of priority, data bytes 00, 11 .. ff
  localparam logic [7:0] FillPrio [16] = '{8'hff, 8'h00, 8'h80, 8'h80, 8'h80, 8'h01,
                                           8'hfe, 8'h00, 8'hff, 8'h7f, 8'h40, 8'h40,
                                           8'h10, 8'h20, 8'hc0, 8'h80};

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [7:0] item_data, [15:8] item_priority
  logic [1:0]  s_tuser  = ACT_NONE;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [2:0] status, [10:3] out_data,
                                // [18:11] out_priority, [23:19] zero
  logic        m_tlast;

  int mismatches;
  int outstanding;
  int checked;
  int sent [4];

  bit tx_calm;
  bit rx_calm;
  bit rx_hold_req;

  stable_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  spq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one, none in calm stretches
  function automatic int pick_gap(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 2);
  endfunction

  // offer one item from a falling edge and hold it until taken
  task automatic send(action_t act, logic [7:0] d, logic [7:0] p);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {p, d};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent[act]++;
  endtask

  // stop offering and wait until every owed result has left
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold when asked
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        n = pick_gap(rx_calm);
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int  random_sent;
    int  phase_len;
    int  enq_weight;
    int  r;
    bit  narrow;
    bit  first;
    bit  paused;
    action_t act;
    logic [7:0] d;
    logic [7:0] p;
    random_sent = 0;
    first = 1'b1;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty queue, unused code, fill with ties, overflow, list, drain
    send(ACT_DEQUEUE, 8'h5a, 8'ha5);
    send(ACT_LIST, 8'hff, 8'hff);
    send(ACT_NONE, 8'h3c, 8'h00);
    for (int i = 0; i < Capacity; i++) send(ACT_ENQUEUE, 8'(i * 17), FillPrio[i]);
    send(ACT_ENQUEUE, 8'haa, 8'h00);
    send(ACT_LIST, 8'h00, 8'h00);
    send(ACT_DEQUEUE, 8'h00, 8'h00);
    send(ACT_DEQUEUE, 8'hff, 8'hff);
    wait_drained();

    // random phases that fill, drain or churn the queue
    while (random_sent < RandomItems) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       enq_weight = 80;
        1:       enq_weight = 20;
        default: enq_weight = 50;
      endcase
      narrow  = $urandom_range(0, 1);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (first) begin
        // fill while the receiver holds off so the input backs up
        enq_weight  = 80;
        tx_calm     = 1'b1;
        rx_hold_req = 1'b1;
        first       = 1'b0;
      end
      if (!paused && random_sent >= RandomItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      for (int k = 0; k < phase_len && random_sent < RandomItems; k++) begin
        r = $urandom_range(0, 99);
        d = 8'($urandom);
        p = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
        if (r < 3)                                   act = ACT_NONE;
        else if (r < 13)                             act = ACT_LIST;
        else if ($urandom_range(0, 99) < enq_weight) act = ACT_ENQUEUE;
        else                                         act = ACT_DEQUEUE;
        send(act, d, p);
        if (act != ACT_NONE) random_sent++;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    $display("Sent %0d enqueue, %0d dequeue, %0d list and %0d unused-code items.",
             sent[ACT_ENQUEUE], sent[ACT_DEQUEUE], sent[ACT_LIST], sent[ACT_NONE]);
    $display("Checked %0d result items; %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Timed out with %0d results still owed.", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
